@@ hw/rtl/mnso_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI note sine oscillator package
// Shared field widths, command codes, unit request types and the constant
// functions for the note frequency table and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package mnso_pkg;

	localparam int NOTE_W  = 7;
	localparam int LEVEL_W = 7;
	localparam int SR_W    = 18;
	localparam int FREQ_W  = 30;
	localparam logic [SR_W-1:0] SR_RESET = 18'd44100;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Command codes of an input item.
	localparam logic CMD_NOTE_ON = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Request to the phase step divider.
	typedef struct packed {
		logic              start;
		logic [NOTE_W-1:0] note;
		logic [SR_W-1:0]   rate;
	} div_req_t;

	// Request to the sine lookup and level scaler.
	typedef struct packed {
		logic               start;
		logic [LEVEL_W-1:0] level;
	} amp_req_t;

	// Q14.16 frequency of the notes of the top octave (notes 120 to 131).
	function automatic logic [FREQ_W-1:0] top_octave(input logic [3:0] semi);
		logic [FREQ_W-1:0] f;
		case (semi)
			4'd0:    f = 30'd548668578;
			4'd1:    f = 30'd581294109;
			4'd2:    f = 30'd615859655;
			4'd3:    f = 30'd652480578;
			4'd4:    f = 30'd691279090;
			4'd5:    f = 30'd732384684;
			4'd6:    f = 30'd775934544;
			4'd7:    f = 30'd822074013;
			4'd8:    f = 30'd870957077;
			4'd9:    f = 30'd922746880;
			4'd10:   f = 30'd977616265;
			4'd11:   f = 30'd1035748353;
			default: f = '0;
		endcase
		return f;
	endfunction

	// Q14.16 frequency of a MIDI note: the top-octave value shifted down by
	// the octave distance, rounding half up. The octave is note / 12, taken
	// by a reciprocal multiply that is exact over seven-bit notes.
	function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] note);
		logic [17:0]       prod;
		logic [3:0]        oct;
		logic [6:0]        rest;
		logic [3:0]        sh;
		logic [FREQ_W-1:0] base;
		logic [FREQ_W:0]   sum;
		prod = 18'(note) * 18'd171;
		oct  = prod[14:11];
		rest = note - 7'(7'(oct) * 7'd12);
		base = top_octave(rest[3:0]);
		sh   = 4'd10 - oct;
		if (sh == 4'd0) begin
			return base;
		end
		sum = {1'b0, base} + ((FREQ_W+1)'(1) << (sh - 4'd1));
		return FREQ_W'(sum >> sh);
	endfunction

	// Sine magnitude for quarter-wave position k out of 2^qbits, scaled to
	// 2^(out_bits-1)-1, from a Q30 Taylor series up to the x^11 term.
	function automatic longint unsigned sine_mag(input int unsigned k,
			input int unsigned qbits, input int unsigned out_bits);
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned fs;
		longint          sum;
		r    = longint'(k) << (28 - qbits);
		x    = (r * HALF_PI_Q30) >> 28;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		fs = (64'd1 << (out_bits - 1)) - 64'd1;
		return (longint'(sum) * fs + (64'd1 << 29)) >> 30;
	endfunction

endpackage

@@ hw/rtl/mnso_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Command channel
// Carries note-on messages and sample ticks into the oscillator.
// ----------------------------------------------------------------------------
interface mnso_cmd_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [mnso_pkg::NOTE_W-1:0]  note_number;
	logic [mnso_pkg::LEVEL_W-1:0] velocity;

	modport source (output valid, command, note_number, velocity, input ready);
	modport sink (input valid, command, note_number, velocity, output ready);
endinterface

@@ hw/rtl/mnso_audio_if.sv @@
// ----------------------------------------------------------------------------
// Audio channel
// Carries one signed audio sample and the note activity flag per tick.
// ----------------------------------------------------------------------------
interface mnso_audio_if #(
	parameter int OUTPUT_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [OUTPUT_BITS-1:0] sample;
	logic                          note_active;

	modport source (output valid, sample, note_active, input ready);
	modport sink (input valid, sample, note_active, output ready);
endinterface

@@ hw/rtl/mnso_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the sample rate register value.
// ----------------------------------------------------------------------------
interface mnso_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [mnso_pkg::SR_W-1:0] sample_rate;

	modport source (output valid, sample_rate, input ready);
	modport sink (input valid, sample_rate, output ready);
endinterface

@@ hw/rtl/mnso_step_div.sv @@
// ----------------------------------------------------------------------------
// Phase step divider
// Restoring division, one quotient bit per cycle, of the note frequency
// scaled to the phase width by the sample rate, rounded to nearest.
// ----------------------------------------------------------------------------
module mnso_step_div #(
	parameter int PHASE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mnso_pkg::div_req_t      req,
	output logic                    done,
	output logic [PHASE_BITS-1:0]   step
);

	localparam int DIV_W = mnso_pkg::FREQ_W + PHASE_BITS - 15;
	localparam int CNT_W = $clog2(DIV_W);
	localparam int SR_W  = mnso_pkg::SR_W;

	logic [DIV_W-1:0]      dividend_q;
	logic [SR_W-1:0]       rem_q;
	logic [SR_W-1:0]       rate_q;
	logic                  zero_q;
	logic [PHASE_BITS-1:0] quot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [SR_W:0]         rem_shift;
	logic                  fits;
	logic [DIV_W-1:0]      num;

	// Numerator with half the divisor added for rounding.
	assign num = (DIV_W'(mnso_pkg::note_freq(req.note)) << (PHASE_BITS - 16))
		+ DIV_W'(req.rate >> 1);

	// One restoring step: bring down the next bit and try a subtract.
	assign rem_shift = {rem_q, dividend_q[DIV_W-1]};
	assign fits      = rem_shift >= {1'b0, rate_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= num;
			rem_q      <= '0;
			rate_q     <= req.rate;
			zero_q     <= req.rate == '0;
			quot_q     <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[DIV_W-2:0], 1'b0};
			rem_q      <= fits ? SR_W'(rem_shift - {1'b0, rate_q}) : SR_W'(rem_shift);
			quot_q     <= {quot_q[PHASE_BITS-2:0], fits};
		end
	end

	// A zero sample rate gives a zero step.
	assign step = zero_q ? '0 : quot_q;
	assign done = done_q;

endmodule

@@ hw/rtl/mnso_phase_acc.sv @@
// ----------------------------------------------------------------------------
// Bit-serial phase accumulator
// Holds the phase and the phase step as rotating shift registers and adds
// the step to the phase one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module mnso_phase_acc #(
	parameter int PHASE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  step_load,
	input  logic [PHASE_BITS-1:0] step_in,
	output logic                  done,
	output logic [PHASE_BITS-1:0] phase
);

	localparam int CNT_W = $clog2(PHASE_BITS);

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic                  carry_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  sum_bit;
	logic                  carry_nxt;

	// Full adder on the low bits of both words.
	assign sum_bit   = phase_q[0] ^ step_q[0] ^ carry_q;
	assign carry_nxt = (phase_q[0] & step_q[0]) | (carry_q & (phase_q[0] ^ step_q[0]));

	// Sequencing of one pass over all bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PHASE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Phase and step state; both are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			carry_q <= 1'b0;
		end else if (start) begin
			carry_q <= 1'b0;
		end else if (busy_q) begin
			phase_q <= {sum_bit, phase_q[PHASE_BITS-1:1]};
			step_q  <= {step_q[0], step_q[PHASE_BITS-1:1]};
			carry_q <= carry_nxt;
		end else if (step_load) begin
			step_q <= step_in;
		end
	end

	assign done  = done_q;
	assign phase = phase_q;

endmodule

@@ hw/rtl/mnso_sine_amp.sv @@
// ----------------------------------------------------------------------------
// Sine lookup and level scaler
// Reads a quarter-wave sine table at the top phase bits, then scales the
// magnitude by the level with a shift-add multiply, one level bit per cycle.
// ----------------------------------------------------------------------------
module mnso_sine_amp #(
	parameter int PHASE_BITS       = 32,
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int OUTPUT_BITS      = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mnso_pkg::amp_req_t            req,
	input  logic [PHASE_BITS-1:0]         phase,
	output logic                          done,
	output logic signed [OUTPUT_BITS-1:0] sample
);

	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int Q_BITS  = IDX_W - 2;
	localparam int QUARTER = 1 << Q_BITS;
	localparam int MAG_W   = OUTPUT_BITS - 1;
	localparam int LEVEL_W = mnso_pkg::LEVEL_W;
	localparam int PROD_W  = MAG_W + LEVEL_W;
	localparam int CNT_W   = $clog2(LEVEL_W);

	logic [MAG_W-1:0]   rom [0:QUARTER];
	logic [IDX_W-1:0]   idx;
	logic [IDX_W-2:0]   k;
	logic [MAG_W-1:0]   mag_s1;
	logic               neg_s1;
	logic [LEVEL_W-1:0] lvl_q;
	logic [PROD_W-1:0]  acc_q;
	logic [MAG_W:0]     part;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MAG_W-1:0]   scaled;

	// Constant quarter-wave table, both end points included.
	for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
		assign rom[g] = MAG_W'(mnso_pkg::sine_mag(g, Q_BITS, OUTPUT_BITS));
	end

	// Table position: mirrored in the second and fourth quadrants.
	assign idx = phase[PHASE_BITS-1 -: IDX_W];
	assign k   = idx[IDX_W-2] ? (IDX_W-1)'(QUARTER) - {1'b0, idx[Q_BITS-1:0]}
		: {1'b0, idx[Q_BITS-1:0]};

	// Shift-add step: add the magnitude when the level bit is set.
	assign part = {1'b0, acc_q[PROD_W-1:LEVEL_W]} + (lvl_q[0] ? {1'b0, mag_s1} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Table read on start, then the serial multiply.
	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_s1 <= rom[k];
			neg_s1 <= idx[IDX_W-1];
			lvl_q  <= req.level;
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= {part, acc_q[LEVEL_W-1:1]};
			lvl_q <= {1'b0, lvl_q[LEVEL_W-1:1]};
		end
	end

	// The product divided by 128, with the sign of the sine applied.
	assign scaled = acc_q[PROD_W-1:LEVEL_W];
	assign sample = neg_s1 ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
	assign done   = done_q;

endmodule

@@ hw/rtl/midi_note_sine_oscillator.sv @@
// ----------------------------------------------------------------------------
// MIDI note sine oscillator
// Monophonic sine source: a note-on sets the phase step and the level; each
// sounding sample tick advances the phase and returns the scaled sine sample.
// ----------------------------------------------------------------------------
//
// Channel   Role   Payload                            Transfer
// cmd       sink   command, note_number, velocity     valid && ready
// audio     source sample, note_active                valid && ready
// cfg       sink   sample_rate                        valid && ready
//
// A sounding tick runs the bit-serial phase add over all PHASE_BITS bits,
// one table read and seven shift-add steps. A silent tick returns a zero
// sample without a phase step. A note-on runs the one-bit-per-cycle divider
// and gives no result.
// Reset clears phase, step, level and sets the sample rate to 44100.
// A new command is taken while a finished sample waits on a stalled audio.
//
module midi_note_sine_oscillator #(
	parameter int PHASE_BITS       = 32,
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int OUTPUT_BITS      = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	mnso_cmd_if.sink            cmd,
	mnso_audio_if.source        audio,
	mnso_cfg_if.sink            cfg
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_PHASE = 5'b00100,
		ST_AMP   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t                             state_q;
	logic [mnso_pkg::SR_W-1:0]          rate_q;
	logic [mnso_pkg::LEVEL_W-1:0]       level_q;
	logic                               sounding_q;
	logic signed [OUTPUT_BITS-1:0]      res_sample_q;
	logic                               res_active_q;
	logic signed [OUTPUT_BITS-1:0]      out_sample_q;
	logic                               out_active_q;
	logic                               out_valid_q;

	logic                               cmd_xfer;
	logic                               out_load;
	mnso_pkg::div_req_t                 div_req;
	mnso_pkg::amp_req_t                 amp_req;
	logic                               div_done;
	logic [PHASE_BITS-1:0]              div_step;
	logic                               phase_start;
	logic                               phase_done;
	logic [PHASE_BITS-1:0]              phase;
	logic                               amp_done;
	logic signed [OUTPUT_BITS-1:0]      amp_sample;

	assign cmd.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || audio.ready);

	// Unit requests.
	assign div_req.start = cmd_xfer && (cmd.command == mnso_pkg::CMD_NOTE_ON);
	assign div_req.note  = cmd.note_number;
	assign div_req.rate  = rate_q;
	assign phase_start   = cmd_xfer && (cmd.command == mnso_pkg::CMD_TICK) && sounding_q;
	assign amp_req.start = (state_q == ST_PHASE) && phase_done;
	assign amp_req.level = level_q;

	mnso_step_div #(
		.PHASE_BITS (PHASE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.step   (div_step)
	);

	mnso_phase_acc #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (phase_start),
		.step_load (div_done),
		.step_in   (div_step),
		.done      (phase_done),
		.phase     (phase)
	);

	mnso_sine_amp #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.OUTPUT_BITS      (OUTPUT_BITS)
	) u_amp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (amp_req),
		.phase  (phase),
		.done   (amp_done),
		.sample (amp_sample)
	);

	// Sample rate register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= mnso_pkg::SR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			rate_q <= cfg.sample_rate;
		end
	end

	// Sequencer and note state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			level_q    <= '0;
			sounding_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						if (cmd.command == mnso_pkg::CMD_NOTE_ON) begin
							level_q    <= cmd.velocity;
							sounding_q <= cmd.velocity != '0;
							state_q    <= ST_DIV;
						end else if (sounding_q) begin
							state_q <= ST_PHASE;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PHASE: begin
					if (phase_done) begin
						state_q <= ST_AMP;
					end
				end
				ST_AMP: begin
					if (amp_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result of the current tick: silence, or the scaled sine sample.
	always_ff @(posedge clk) begin
		if (cmd_xfer && (cmd.command == mnso_pkg::CMD_TICK) && !sounding_q) begin
			res_sample_q <= '0;
			res_active_q <= 1'b0;
		end else if ((state_q == ST_AMP) && amp_done) begin
			res_sample_q <= amp_sample;
			res_active_q <= 1'b1;
		end
	end

	// Output register toward the audio channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (audio.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= res_sample_q;
			out_active_q <= res_active_q;
		end
	end

	assign audio.valid       = out_valid_q;
	assign audio.sample      = out_sample_q;
	assign audio.note_active = out_active_q;

	// A silent result always carries a zero sample.
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_active_q |-> out_sample_q == '0)
		else $error("silent result with nonzero sample");

	// The serial units never finish in the same cycle.
	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({div_done, phase_done, amp_done}))
		else $error("two units finished together");

	// A finished note-on returns the sequencer to idle.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && div_done |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after note-on");

	// A tick on a silent note takes no phase step.
	a_silent_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer && (cmd.command == mnso_pkg::CMD_TICK) && !sounding_q |=> $stable(phase))
		else $error("phase moved on a silent tick");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI note sine oscillator testbench
// Drives note-on messages and sample ticks into the oscillator under several
// sample rate settings. Each audio sample is checked against its hand-written
// expectation or else an in-bench model of the phase accumulator, the sine
// table and the level scaling. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PHASE_W         = 32;
	localparam int LUT_BITS        = 10;
	localparam int LUT_DEPTH       = 1 << LUT_BITS;
	localparam int SAMPLE_W        = 16;
	localparam longint unsigned PEAK          = 64'd32767;
	localparam longint unsigned PI_OVER_2_Q30 = 64'd1686629713;
	localparam int RATE_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 228;
	localparam int SETTLE_CYCLES   = 100;
	localparam int STALL_LIMIT     = 4000;
	localparam int MAX_WAIT        = 17;
	localparam int REPORT_LIMIT    = 10;

	// One command for the oscillator, with an optional hand-written expectation.
	typedef struct packed {
		logic                             command;
		logic [mnso_pkg::NOTE_W-1:0]      note;
		logic [mnso_pkg::LEVEL_W-1:0]     velocity;
		logic                             typed;
		logic signed [SAMPLE_W-1:0]       want_sample;
		logic                             want_active;
	} stim_row_t;

	// One audio transfer.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       note_active;
	} audio_word_t;

	logic clk;
	logic arst_n;

	mnso_cmd_if                               cmd_ch();
	mnso_audio_if #(.OUTPUT_BITS(SAMPLE_W))   audio_ch();
	mnso_cfg_if                               cfg_ch();

	midi_note_sine_oscillator #(
		.PHASE_BITS       (PHASE_W),
		.SINE_TABLE_DEPTH (LUT_DEPTH),
		.OUTPUT_BITS      (SAMPLE_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.audio  (audio_ch),
		.cfg    (cfg_ch)
	);

	// Q14.16 frequencies of notes 120 to 131; lower octaves are shifted down.
	longint unsigned top_octave_q16 [12] = '{
		64'd548668578, 64'd581294109, 64'd615859655, 64'd652480578,
		64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
		64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
	};

	// Oscillator model state.
	int                           sine_lut [LUT_DEPTH];
	logic [mnso_pkg::SR_W-1:0]    osc_rate;
	logic [PHASE_W-1:0]           osc_phase;
	logic [PHASE_W-1:0]           osc_step;
	logic                         osc_sounding;
	logic [mnso_pkg::LEVEL_W-1:0] osc_level;
	audio_word_t                  pending_audio [$];

	int mismatches;
	int results_seen;
	int notes_sent;
	int ticks_sent;
	int rate_writes;
	bit src_steady;
	bit sink_steady;

	// Directed part: silence after reset, extreme notes and velocities, ignored
	// fields on ticks, a velocity-zero note-on, and the unshifted top octave.
	stim_row_t directed_rows [23] = '{
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b1, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd127, 7'd127, 1'b1, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_NOTE_ON, 7'd69,  7'd127, 1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd127, 7'd127, 1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_NOTE_ON, 7'd0,   7'd1,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_NOTE_ON, 7'd127, 7'd127, 1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_NOTE_ON, 7'd60,  7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b1, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd85,  7'd42,  1'b1, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_NOTE_ON, 7'd120, 7'd64,  1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_NOTE_ON, 7'd42,  7'd85,  1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0},
		'{mnso_pkg::CMD_TICK,    7'd0,   7'd0,   1'b0, 16'sd0, 1'b0}
	};

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Signed sine table entry from a Q30 Taylor series over one quarter wave.
	function automatic int sine_value(input int unsigned i);
		longint unsigned t;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned mag;
		longint          sum;
		int unsigned     quad;
		int              k;
		t    = (longint'(i) << 30) / LUT_DEPTH;
		quad = int'((t >> 28) & 64'd3);
		r    = t & ((64'd1 << 28) - 64'd1);
		if (quad[0]) begin
			r = (64'd1 << 28) - r;
		end
		x    = (r * PI_OVER_2_Q30) >> 28;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (k = 1; k <= 5; k++) begin
			term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		mag = (unsigned'(sum) * PEAK + (64'd1 << 29)) >> 30;
		return (quad >= 2) ? -int'(mag) : int'(mag);
	endfunction

	// Phase increment of a note: round(freq * 2^32 / rate), zero for rate zero.
	function automatic logic [PHASE_W-1:0] note_step(
			input logic [mnso_pkg::NOTE_W-1:0] note,
			input logic [mnso_pkg::SR_W-1:0] rate);
		int unsigned     octave;
		int unsigned     shift;
		longint unsigned freq;
		longint unsigned rate64;
		octave = note / 12;
		shift  = 10 - octave;
		freq   = top_octave_q16[note % 12];
		if (shift != 0) begin
			freq = (freq + (64'd1 << (shift - 1))) >> shift;
		end
		if (rate == '0) begin
			return '0;
		end
		rate64 = rate;
		return PHASE_W'(((freq << (PHASE_W - 16)) + rate64 / 2) / rate64);
	endfunction

	// Applies one command to the oscillator model; returns 1 when a sample is due.
	function automatic bit oscillator_step(input stim_row_t row, output audio_word_t word);
		logic [LUT_BITS-1:0] idx;
		int                  s;
		int unsigned         mag;
		word = '0;
		if (row.command == mnso_pkg::CMD_NOTE_ON) begin
			osc_step     = note_step(row.note, osc_rate);
			osc_level    = row.velocity;
			osc_sounding = (row.velocity != '0);
			return 1'b0;
		end
		if (osc_sounding) begin
			osc_phase        = osc_phase + osc_step;
			idx              = osc_phase[PHASE_W-1 -: LUT_BITS];
			s                = sine_lut[idx];
			mag              = (((s < 0) ? -s : s) * osc_level) >> 7;
			word.sample      = (s < 0) ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
			word.note_active = 1'b1;
		end
		return 1'b1;
	endfunction

	// Random command: mostly ticks, with note-ons that sometimes silence.
	function automatic stim_row_t random_row();
		stim_row_t row;
		row          = '0;
		row.command  = ($urandom_range(0, 99) < 15) ? mnso_pkg::CMD_NOTE_ON
			: mnso_pkg::CMD_TICK;
		row.note     = mnso_pkg::NOTE_W'($urandom_range(0, 127));
		row.velocity = mnso_pkg::LEVEL_W'($urandom_range(0, 127));
		if (row.command == mnso_pkg::CMD_NOTE_ON && $urandom_range(0, 7) == 0) begin
			row.velocity = '0;
		end
		return row;
	endfunction

	// Compares one audio transfer with the oldest expected sample.
	task automatic check_audio(input audio_word_t got);
		audio_word_t want;
		results_seen++;
		if (pending_audio.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("unexpected audio transfer: sample %0d active %0b",
					got.sample, got.note_active);
			end
			return;
		end
		want = pending_audio.pop_front();
		if (got.sample !== want.sample || got.note_active !== want.note_active) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("audio result %0d: expected sample %0d active %0b, got sample %0d active %0b",
					results_seen, want.sample, want.note_active, got.sample, got.note_active);
			end
		end
	endtask

	// Sends one command after a random gap and records the sample it should give.
	task automatic play(input stim_row_t row);
		int          gap;
		bit          drain;
		audio_word_t word;
		if ($urandom_range(0, 39) == 0) begin
			src_steady = !src_steady;
		end
		gap   = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
		drain = ($urandom_range(0, 149) == 0);
		if (gap != 0 || (drain && pending_audio.size() != 0)) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && pending_audio.size() != 0) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.command     <= row.command;
		cmd_ch.note_number <= row.note;
		cmd_ch.velocity    <= row.velocity;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		if (oscillator_step(row, word)) begin
			if (row.typed) begin
				word.sample      = row.want_sample;
				word.note_active = row.want_active;
			end
			pending_audio.push_back(word);
			ticks_sent++;
		end else begin
			notes_sent++;
		end
	endtask

	// Waits for every expected sample, then for a note-on still in the divider.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (pending_audio.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One configuration transfer of the sample rate register.
	task automatic write_rate(input logic [mnso_pkg::SR_W-1:0] rate);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.sample_rate <= rate;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		osc_rate = rate;
		rate_writes++;
	endtask

	// Audio sink with random stalls and stretches without any.
	initial begin : audio_sink
		int          stall;
		audio_word_t got;
		audio_ch.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				sink_steady = !sink_steady;
			end
			stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall != 0) begin
				audio_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			audio_ch.ready <= 1'b1;
			@(posedge clk);
			while (!audio_ch.valid) @(posedge clk);
			got.sample      = audio_ch.sample;
			got.note_active = audio_ch.note_active;
			check_audio(got);
		end
	end

	// Ends the run when no channel has moved a transfer for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (audio_ch.valid && audio_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("no transfer for %0d cycles, %0d samples outstanding",
			STALL_LIMIT, pending_audio.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus: directed rows at the reset rate, then random phases per rate.
	initial begin : stimulus
		logic [mnso_pkg::SR_W-1:0] rate_plan [RATE_PHASES];
		int                        i;
		int                        p;
		for (i = 0; i < LUT_DEPTH; i++) begin
			sine_lut[i] = sine_value(i);
		end
		osc_rate           = mnso_pkg::SR_RESET;
		osc_phase          = '0;
		osc_step           = '0;
		osc_sounding       = 1'b0;
		osc_level          = '0;
		arst_n             = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.command     = mnso_pkg::CMD_TICK;
		cmd_ch.note_number = '0;
		cmd_ch.velocity    = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.sample_rate = mnso_pkg::SR_RESET;

		// Range extremes, zero, far below range, all ones, 48000, then random ones.
		rate_plan = '{18'd8000, 18'd192000, 18'd0, 18'd3, 18'h3FFFF, 18'd48000,
			18'd0, 18'd0};
		rate_plan[6] = mnso_pkg::SR_W'($urandom_range(8000, 192000));
		rate_plan[7] = mnso_pkg::SR_W'($urandom_range(0, 262143));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			play(directed_rows[i]);
		end

		// The phase step stays from the old rate until the next note-on.
		for (p = 0; p < RATE_PHASES; p++) begin
			settle();
			write_rate(rate_plan[p]);
			repeat (ITEMS_PER_PHASE) play(random_row());
		end
		settle();

		$display("Sent %0d note-ons and %0d sample ticks across %0d sample rate settings.",
			notes_sent, ticks_sent, rate_writes + 1);
		$display("Checked %0d audio samples, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
